// ----- hdl/npcw_pkg.sv -----
// Shared types and constants for the NVM page cache write-back block.
// Used by every module under hdl/; no dependencies of its own.
package npcw_pkg;

	localparam int PAGE_BYTES     = 512;
	localparam int RESERVED_BYTES = 32;
	localparam int CHUNK_BYTES    = 16;
	localparam int ROWS           = PAGE_BYTES / CHUNK_BYTES;
	localparam int ROW_W          = $clog2(ROWS);
	localparam int LANE_W         = $clog2(CHUNK_BYTES);
	localparam int LOC_W          = $clog2(PAGE_BYTES);
	localparam logic [31:0] UNLOCK_MAGIC = 32'h003fadeb;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_LOAD  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_ERASE = 2'd2,
		CMD_QUAD  = 2'd3
	} flash_cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_CLEAR = 2'd1,
		PH_ERASE = 2'd2,
		PH_DATA  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		REG_USER_LIMIT = 2'd0,
		REG_RSV_START  = 2'd1,
		REG_UNLOCK     = 2'd2,
		REG_UV_TRIP    = 2'd3
	} reg_index_t;

	// classified transaction handed from front to back
	typedef struct packed {
		action_t      action;
		logic [LOC_W:0] idx;
		logic [1:0]   size;
		logic [3:0]   nbytes;
		logic         inb;
		logic         allow;
		logic [63:0]  wdata;
		logic         ready;
		logic         loaded;
		logic [15:0]  supply;
	} item_t;

endpackage

// ----- hdl/npcw_front.sv -----
// Front end: accepts input transactions and classifies them (bounds, lock).
// Depends on npcw_pkg.
module npcw_front import npcw_pkg::*; (
	input  logic               action,
	input  logic [1:0]         action_code,
	input  logic [LOC_W-1:0]   location,
	input  logic [1:0]         size_code,
	input  logic signed [63:0] write_value,
	input  logic               controller_ready,
	input  logic               buffer_loaded,
	input  logic [15:0]        supply_level,
	input  logic [LOC_W-1:0]   user_limit,
	input  logic [LOC_W-1:0]   reserved_start,
	input  logic [31:0]        unlock_code,
	output item_t              item
);

	logic [3:0]       n;
	logic [LOC_W:0]   end_user;
	logic [LOC_W:0]   idx;
	logic [LOC_W+1:0] end_page;
	logic             inb;
	logic             locked;
	logic             is_load;

	always_comb begin
		is_load  = action && (action_code == ACT_LOAD);
		n        = 4'd1 << size_code;
		end_user = {1'b0, location} + (LOC_W+1)'(n);
		idx      = {1'b0, location} + (LOC_W+1)'(RESERVED_BYTES);
		end_page = {1'b0, idx} + (LOC_W+2)'(n);
		inb      = (end_user <= {1'b0, user_limit}) && (end_page <= (LOC_W+2)'(PAGE_BYTES));
		locked   = (end_user > {1'b0, reserved_start}) && (unlock_code != UNLOCK_MAGIC);

		item.action = action_t'(action_code);
		item.wdata  = write_value;
		item.ready  = controller_ready;
		item.loaded = buffer_loaded;
		item.supply = supply_level;
		if (is_load) begin
			item.idx    = {1'b0, location};
			item.size   = 2'd0;
			item.nbytes = 4'd1;
			item.inb    = 1'b1;
			item.allow  = 1'b1;
		end else begin
			item.idx    = idx;
			item.size   = size_code;
			item.nbytes = n;
			item.inb    = inb;
			item.allow  = inb && !locked;
		end
	end

endmodule

// ----- hdl/npcw_queue.sv -----
// Two-entry queue of classified transactions between front and back.
// Depends on npcw_pkg.
module npcw_queue import npcw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  empty,
	output logic  full
);

	item_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head  = ent_q[rd_ptr_q];
	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ----- hdl/npcw_back.sv -----
// Back end: banked page cache, access execution, write-back sequencer and
// output register. Depends on npcw_pkg.
module npcw_back import npcw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  item_t              head,
	input  logic               q_empty,
	output logic               pop,
	output logic               clearing,
	input  logic [15:0]        undervoltage_trip,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] read_value,
	output logic               accepted,
	output logic [1:0]         flash_command,
	output logic [LOC_W-1:0]   flash_address,
	output logic [63:0]        quad_low,
	output logic [63:0]        quad_high,
	output logic               busy_res,
	output logic               aborted
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t           state_q;
	logic [ROW_W-1:0] clr_q;
	item_t            cur_s1;
	logic [ROW_W-1:0] row_q  [CHUNK_BYTES];
	logic [7:0]       rdat_q [CHUNK_BYTES];
	logic [7:0]       mem    [CHUNK_BYTES][ROWS];
	phase_t           phase_q;
	logic [ROW_W-1:0] chunk_q;
	logic             pend_q;

	logic [ROW_W-1:0] rd_row  [CHUNK_BYTES];
	logic [ROW_W-1:0] wr_row  [CHUNK_BYTES];
	logic [7:0]       wr_dat  [CHUNK_BYTES];
	logic             wr_en   [CHUNK_BYTES];

	logic [63:0]      raw;
	logic [63:0]      mask;
	logic [63:0]      newv;
	logic [63:0]      rv;
	logic             changed;
	logic             do_write;
	phase_t           ph_n;
	logic [ROW_W-1:0] chunk_n;
	logic             pend_n;
	flash_cmd_t       cmd_n;
	logic [LOC_W-1:0] addr_n;
	logic [63:0]      qlo_n;
	logic [63:0]      qhi_n;
	logic             ab_n;
	logic             acc_n;
	logic [63:0]      rd_n;
	logic             go;
	logic [LANE_W-1:0] lane;
	logic [LANE_W-1:0] j;

	assign clearing = (state_q == ST_CLEAR);
	assign pop      = (state_q == ST_IDLE) && !q_empty && (!out_valid || !out_stall);

	// read rows for the transaction at the queue head
	always_comb begin
		for (int b = 0; b < CHUNK_BYTES; b++) begin
			if (head.action == ACT_TICK) begin
				rd_row[b] = chunk_q;
			end else if (LANE_W'(b) >= head.idx[LANE_W-1:0]) begin
				rd_row[b] = head.idx[LOC_W-1:LANE_W];
			end else begin
				rd_row[b] = head.idx[LOC_W-1:LANE_W] + ROW_W'(1);
			end
		end
	end

	// execute stage
	always_comb begin
		lane = '0;
		j    = '0;
		for (int k = 0; k < 8; k++) begin
			lane = cur_s1.idx[LANE_W-1:0] + LANE_W'(k);
			raw[8*k +: 8] = rdat_q[lane];
		end

		unique case (cur_s1.size)
			2'd0: mask = 64'h0000_0000_0000_00ff;
			2'd1: mask = 64'h0000_0000_0000_ffff;
			2'd2: mask = 64'h0000_0000_ffff_ffff;
			default: mask = '1;
		endcase

		unique case (cur_s1.size)
			2'd0: rv = {{56{raw[7]}}, raw[7:0]};
			2'd1: rv = {{48{raw[15]}}, raw[15:0]};
			2'd2: rv = {{32{raw[31]}}, raw[31:0]};
			default: rv = {raw[31:0], raw[63:32]};
		endcase

		if (cur_s1.action == ACT_LOAD) begin
			newv = {56'd0, cur_s1.wdata[7:0]};
		end else if (cur_s1.size == 2'd3) begin
			newv = {cur_s1.wdata[31:0], cur_s1.wdata[63:32]};
		end else begin
			newv = cur_s1.wdata & mask;
		end
		changed = (raw & mask) != newv;

		ph_n    = phase_q;
		chunk_n = chunk_q;
		pend_n  = pend_q;
		cmd_n   = CMD_NONE;
		addr_n  = '0;
		qlo_n   = '0;
		qhi_n   = '0;
		ab_n    = 1'b0;
		acc_n   = 1'b0;
		rd_n    = '0;
		do_write = 1'b0;
		go      = 1'b1;

		unique case (cur_s1.action)
			ACT_READ: begin
				acc_n = cur_s1.inb;
				rd_n  = cur_s1.inb ? rv : '1;
			end
			ACT_WRITE: begin
				acc_n = cur_s1.allow;
				if (cur_s1.allow && changed) begin
					do_write = 1'b1;
					pend_n   = 1'b1;
				end
			end
			ACT_LOAD: begin
				acc_n    = 1'b1;
				do_write = 1'b1;
			end
			default: begin
				if (ph_n == PH_IDLE) begin
					if (pend_q) begin
						ph_n = PH_CLEAR;
					end else begin
						go = 1'b0;
					end
				end
				if (go && ph_n == PH_CLEAR) begin
					if (cur_s1.loaded) begin
						if (cur_s1.ready) begin
							cmd_n = CMD_CLEAR;
							ph_n  = PH_ERASE;
						end
						go = 1'b0;
					end else begin
						ph_n = PH_ERASE;
					end
				end
				if (go && ph_n == PH_ERASE) begin
					if (cur_s1.ready) begin
						chunk_n = '0;
						if (cur_s1.supply < undervoltage_trip) begin
							ph_n = PH_IDLE;
							ab_n = 1'b1;
						end else begin
							cmd_n = CMD_ERASE;
							ph_n  = PH_DATA;
						end
					end
					go = 1'b0;
				end
				if (go && ph_n == PH_DATA && cur_s1.ready) begin
					cmd_n  = CMD_QUAD;
					addr_n = {chunk_q, {LANE_W{1'b0}}};
					for (int k = 0; k < 8; k++) begin
						qlo_n[8*k +: 8] = rdat_q[k];
						qhi_n[8*k +: 8] = rdat_q[k + 8];
					end
					chunk_n = chunk_q + ROW_W'(1);
					if (chunk_q == ROW_W'(ROWS - 1)) begin
						ph_n   = PH_IDLE;
						pend_n = 1'b0;
					end
				end
			end
		endcase

		for (int b = 0; b < CHUNK_BYTES; b++) begin
			j = LANE_W'(b) - cur_s1.idx[LANE_W-1:0];
			if (state_q == ST_CLEAR) begin
				wr_en[b]  = 1'b1;
				wr_row[b] = clr_q;
				wr_dat[b] = 8'hff;
			end else begin
				wr_en[b]  = (state_q == ST_EXEC) && do_write && ({1'b0, j} < cur_s1.nbytes);
				wr_row[b] = row_q[b];
				wr_dat[b] = newv[8*j[2:0] +: 8];
			end
		end
	end

	// page cache banks, one byte lane each
	always_ff @(posedge clk) begin
		for (int b = 0; b < CHUNK_BYTES; b++) begin
			if (wr_en[b]) begin
				mem[b][wr_row[b]] <= wr_dat[b];
			end
			rdat_q[b] <= mem[b][rd_row[b]];
		end
		if (pop) begin
			cur_s1 <= head;
			for (int b = 0; b < CHUNK_BYTES; b++) begin
				row_q[b] <= rd_row[b];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			phase_q       <= PH_IDLE;
			chunk_q       <= '0;
			pend_q        <= 1'b0;
			out_valid     <= 1'b0;
			read_value    <= '0;
			accepted      <= 1'b0;
			flash_command <= CMD_NONE;
			flash_address <= '0;
			quad_low      <= '0;
			quad_high     <= '0;
			busy_res      <= 1'b0;
			aborted       <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ROW_W'(1);
					if (clr_q == ROW_W'(ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (out_valid && !out_stall) begin
						out_valid <= 1'b0;
					end
					if (pop) begin
						state_q <= ST_EXEC;
					end
				end
				default: begin
					phase_q       <= ph_n;
					chunk_q       <= chunk_n;
					pend_q        <= pend_n;
					out_valid     <= 1'b1;
					read_value    <= rd_n;
					accepted      <= acc_n;
					flash_command <= cmd_n;
					flash_address <= addr_n;
					quad_low      <= qlo_n;
					quad_high     <= qhi_n;
					busy_res      <= pend_n || (ph_n != PH_IDLE);
					aborted       <= ab_n;
					state_q       <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hdl/nvm_page_cache_writeback.sv -----
// Top level of the NVM page cache with write-back sequencer.
// Depends on npcw_pkg, npcw_front, npcw_queue and npcw_back.
//
// In the back end each transaction first reads the sixteen byte-lane banks
// of the page cache, then computes the result, updates the cache and loads
// the output register. A two-entry queue lets the input side run ahead while
// a result waits to be taken. After reset the cache is filled with 0xFF by a
// pass over the rows, one 16-byte row a cycle, during which in_stall is high;
// configuration writes are taken at any time.
module nvm_page_cache_writeback import npcw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [LOC_W-1:0]   location,
	input  logic [1:0]         size_code,
	input  logic signed [63:0] write_value,
	input  logic               controller_ready,
	input  logic               buffer_loaded,
	input  logic [15:0]        supply_level,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] read_value,
	output logic               accepted,
	output logic [1:0]         flash_command,
	output logic [LOC_W-1:0]   flash_address,
	output logic [63:0]        quad_low,
	output logic [63:0]        quad_high,
	output logic               busy_res,
	output logic               aborted
);

	logic [LOC_W-1:0] user_limit_q;
	logic [LOC_W-1:0] reserved_start_q;
	logic [31:0]      unlock_code_q;
	logic [15:0]      uv_trip_q;

	item_t item;
	item_t head;
	logic  push;
	logic  pop;
	logic  q_empty;
	logic  q_full;
	logic  clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_limit_q     <= LOC_W'(480);
			reserved_start_q <= LOC_W'(448);
			unlock_code_q    <= '0;
			uv_trip_q        <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_USER_LIMIT: user_limit_q     <= cfg_data[LOC_W-1:0];
				REG_RSV_START:  reserved_start_q <= cfg_data[LOC_W-1:0];
				REG_UNLOCK:     unlock_code_q    <= cfg_data;
				default:        uv_trip_q        <= cfg_data[15:0];
			endcase
		end
	end

	assign in_stall = q_full || clearing;
	assign push     = in_valid && !in_stall;

	npcw_front u_front (
		.action           (1'b1),
		.action_code      (action),
		.location         (location),
		.size_code        (size_code),
		.write_value      (write_value),
		.controller_ready (controller_ready),
		.buffer_loaded    (buffer_loaded),
		.supply_level     (supply_level),
		.user_limit       (user_limit_q),
		.reserved_start   (reserved_start_q),
		.unlock_code      (unlock_code_q),
		.item             (item)
	);

	npcw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (item),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	npcw_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.head              (head),
		.q_empty           (q_empty),
		.pop               (pop),
		.clearing          (clearing),
		.undervoltage_trip (uv_trip_q),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.read_value        (read_value),
		.accepted          (accepted),
		.flash_command     (flash_command),
		.flash_address     (flash_address),
		.quad_low          (quad_low),
		.quad_high         (quad_high),
		.busy_res          (busy_res),
		.aborted           (aborted)
	);

endmodule
